[rtl/bfl_pkg.sv]
// Shared types and constants for the battery fault latch block.
// No dependencies; imported by every module under rtl/.
package bfl_pkg;

    // Hysteresis margins between a limit and its recovery band.
    localparam logic [10:0] MARGIN_VOLT_MV = 11'd1500;
    localparam logic [10:0] MARGIN_CURR_MA = 11'd2000;
    localparam logic [4:0]  MARGIN_TEMP_DC = 5'd30;

    // Configuration port geometry.
    localparam int CFG_ADDR_BITS = 3;
    localparam int CFG_DATA_BITS = 18;

    // Register indexes on the configuration port.
    typedef enum logic [CFG_ADDR_BITS-1:0] {
        REG_OV_LIMIT  = 3'd0,
        REG_UV_LIMIT  = 3'd1,
        REG_OC_LIMIT  = 3'd2,
        REG_OT_LIMIT  = 3'd3,
        REG_REC_DELAY = 3'd4
    } t_reg_idx;

    // Reset values of the configuration registers.
    localparam logic [16:0] RST_OV_LIMIT  = 17'd54600;
    localparam logic [16:0] RST_UV_LIMIT  = 17'd42000;
    localparam logic [17:0] RST_OC_LIMIT  = 18'd30000;
    localparam logic [11:0] RST_OT_LIMIT  = 12'd600;
    localparam logic [15:0] RST_REC_DELAY = 16'd3000;

    // Fault channel numbering.
    localparam int FLT_OV = 0;
    localparam int FLT_UV = 1;
    localparam int FLT_OC = 2;
    localparam int FLT_OT = 3;
    localparam int NUM_FLT = 4;

    // Current configuration as seen by the datapath.
    typedef struct packed {
        logic [16:0]        ov_limit;
        logic [16:0]        uv_limit;
        logic [17:0]        oc_limit;
        logic signed [11:0] ot_limit;
        logic [15:0]        rec_delay;
    } t_cfg;

    // Status of one fault latch.
    typedef struct packed {
        logic flag;
        logic busy;
    } t_latch_stat;

endpackage

[rtl/battery_fault_latch_with_recovery_core.sv]
// Top level of the battery fault latch block: sample register, limit compares,
// four recovery latches and the result channel. Depends on bfl_pkg,
// bfl_cfg_regs and bfl_latch.
//
//  channel   | direction | handshake           | beat
//  ----------+-----------+---------------------+---------------------------------
//  sample    | in        | i_valid / o_ready   | valid flag, voltage, current,
//            |           |                     | temperature, time
//  result    | out       | o_valid / i_ready   | four fault latches, two disables
//  config    | in        | i_cfg_we            | register index and write data
//
// One sample per cycle while results are taken. A sample is registered on
// acceptance and resolved once the result slot frees: limit compares and
// timer updates write the latches, which drive the result beat directly.
// The latches update only when the result slot is empty or being taken;
// while a result stalls, one more sample waits in the input register.
// Synchronous active-low reset clears latches, timers and the handshake and
// loads the limit defaults.
module battery_fault_latch_with_recovery_core
    import bfl_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_valid,
    output logic                     o_ready,
    input  logic                     i_voltage_valid,
    input  logic [16:0]              i_battery_voltage_mv,
    input  logic signed [18:0]       i_battery_current_ma,
    input  logic signed [11:0]       i_battery_temp_dc,
    input  logic [31:0]              i_time_ms,
    output logic                     o_valid,
    input  logic                     i_ready,
    output logic                     o_over_voltage_fault,
    output logic                     o_under_voltage_fault,
    output logic                     o_over_current_fault,
    output logic                     o_over_temp_fault,
    output logic                     o_charge_disable,
    output logic                     o_load_disable,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data
);

    t_cfg                 cfg;
    t_latch_stat          stat [NUM_FLT];
    logic [NUM_FLT-1:0]   trip;
    logic [NUM_FLT-1:0]   safe;

    logic                 r_in_valid;
    logic                 r_out_valid;
    logic                 r_volt_ok;
    logic [16:0]          r_volt;
    logic signed [18:0]   r_curr;
    logic signed [11:0]   r_temp;
    logic [TIME_BITS-1:0] r_now;

    logic                 advance;
    logic                 in_take;
    logic [TIME_BITS+31:0] time_ext;
    logic [18:0]          abs_curr;
    logic signed [12:0]   temp_x;
    logic signed [12:0]   tlim_x;

    bfl_cfg_regs u_cfg (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_addr (i_cfg_addr),
        .i_cfg_data (i_cfg_data),
        .o_cfg      (cfg)
    );

    // Handshake: move the held sample into the latches when the result slot frees.
    assign advance = r_in_valid && (!r_out_valid || i_ready);
    assign o_ready = !r_in_valid || advance;
    assign in_take = i_valid && o_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid  <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (in_take) begin
                r_in_valid <= 1'b1;
            end else if (advance) begin
                r_in_valid <= 1'b0;
            end
            if (advance) begin
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Capture the sample beat; the time is cut or widened to the timer width.
    assign time_ext = {{TIME_BITS{1'b0}}, i_time_ms};

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_volt_ok <= i_voltage_valid;
            r_volt    <= i_battery_voltage_mv;
            r_curr    <= i_battery_current_ma;
            r_temp    <= i_battery_temp_dc;
            r_now     <= time_ext[TIME_BITS-1:0];
        end
    end

    // Limit compares; margins are added rather than subtracted, so no sum can underflow.
    assign abs_curr = r_curr[18] ? (~r_curr + 19'd1) : r_curr;
    assign temp_x   = {r_temp[11], r_temp};
    assign tlim_x   = {cfg.ot_limit[11], cfg.ot_limit};

    always_comb begin
        trip[FLT_OV] = r_volt > cfg.ov_limit;
        safe[FLT_OV] = ({1'b0, r_volt} + {7'd0, MARGIN_VOLT_MV}) < {1'b0, cfg.ov_limit};
        trip[FLT_UV] = r_volt < cfg.uv_limit;
        safe[FLT_UV] = {1'b0, r_volt} > ({1'b0, cfg.uv_limit} + {7'd0, MARGIN_VOLT_MV});
        trip[FLT_OC] = {1'b0, abs_curr} > {2'b0, cfg.oc_limit};
        safe[FLT_OC] = ({1'b0, abs_curr} + {9'd0, MARGIN_CURR_MA}) < {2'b0, cfg.oc_limit};
        trip[FLT_OT] = temp_x > tlim_x;
        safe[FLT_OT] = (temp_x + $signed({8'd0, MARGIN_TEMP_DC})) < tlim_x;
    end

    // One latch per fault; an invalid sample still produces a result.
    for (genvar k = 0; k < NUM_FLT; k++) begin : g_latch
        bfl_latch #(
            .TIME_BITS (TIME_BITS)
        ) u_latch (
            .i_clk    (i_clk),
            .i_rst_n  (i_rst_n),
            .i_update (advance && r_volt_ok),
            .i_trip   (trip[k]),
            .i_safe   (safe[k]),
            .i_now    (r_now),
            .i_delay  (cfg.rec_delay),
            .o_stat   (stat[k])
        );
    end

    // Result beat: latches hold still while it stalls.
    assign o_valid               = r_out_valid;
    assign o_over_voltage_fault  = stat[FLT_OV].flag;
    assign o_under_voltage_fault = stat[FLT_UV].flag;
    assign o_over_current_fault  = stat[FLT_OC].flag;
    assign o_over_temp_fault     = stat[FLT_OT].flag;
    assign o_charge_disable      = stat[FLT_OV].flag || stat[FLT_OT].flag;
    assign o_load_disable        = stat[FLT_UV].flag || stat[FLT_OC].flag
                                   || stat[FLT_OT].flag;

    // A held sample is not dropped while the result stalls.
    a_hold_sample: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid && !advance |=> r_in_valid)
        else $error("held sample lost while result stalled");

    // A fault clears only after its recovery timer ran.
    for (genvar k = 0; k < NUM_FLT; k++) begin : g_chk
        a_clear_after_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            $past(i_rst_n) && $fell(stat[k].flag) |-> $past(stat[k].busy))
            else $error("fault cleared without a running recovery timer");

        a_trip_idles_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
            advance && r_volt_ok && trip[k] |=> stat[k].flag && !stat[k].busy)
            else $error("trip did not set the fault and idle its timer");
    end

endmodule

[rtl/bfl_cfg_regs.sv]
// Configuration register file for the battery fault latch block.
// Depends on bfl_pkg for register indexes, reset values and t_cfg.
module bfl_cfg_regs
    import bfl_pkg::*;
(
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_cfg_we,
    input  logic [CFG_ADDR_BITS-1:0] i_cfg_addr,
    input  logic [CFG_DATA_BITS-1:0] i_cfg_data,
    output t_cfg                     o_cfg
);

    t_cfg r_cfg;
    t_cfg n_cfg;

    // Decode the write index and replace the addressed register.
    always_comb begin
        n_cfg = r_cfg;
        if (i_cfg_we) begin
            unique case (t_reg_idx'(i_cfg_addr))
                REG_OV_LIMIT:  n_cfg.ov_limit  = i_cfg_data[16:0];
                REG_UV_LIMIT:  n_cfg.uv_limit  = i_cfg_data[16:0];
                REG_OC_LIMIT:  n_cfg.oc_limit  = i_cfg_data[17:0];
                REG_OT_LIMIT:  n_cfg.ot_limit  = $signed(i_cfg_data[11:0]);
                REG_REC_DELAY: n_cfg.rec_delay = i_cfg_data[15:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.ov_limit  <= RST_OV_LIMIT;
            r_cfg.uv_limit  <= RST_UV_LIMIT;
            r_cfg.oc_limit  <= RST_OC_LIMIT;
            r_cfg.ot_limit  <= $signed(RST_OT_LIMIT);
            r_cfg.rec_delay <= RST_REC_DELAY;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    assign o_cfg = r_cfg;

endmodule

[rtl/bfl_latch.sv]
// One fault latch with its hysteresis recovery timer.
// Depends on bfl_pkg for t_latch_stat.
module bfl_latch
    import bfl_pkg::*;
#(
    parameter int TIME_BITS = 32
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_update,
    input  logic                 i_trip,
    input  logic                 i_safe,
    input  logic [TIME_BITS-1:0] i_now,
    input  logic [15:0]          i_delay,
    output t_latch_stat          o_stat
);

    logic                 r_flag;
    logic                 n_flag;
    logic [TIME_BITS-1:0] r_start;
    logic [TIME_BITS-1:0] n_start;
    logic [TIME_BITS-1:0] elapsed;
    logic                 expired;

    // Elapsed time wraps at the timer width; a start of zero means idle.
    assign elapsed = i_now - r_start;
    assign expired = {1'b0, elapsed} > {{(TIME_BITS - 15){1'b0}}, i_delay};

    // Set on trip, time the stay in the safe band, restart elsewhere.
    always_comb begin
        n_flag  = r_flag;
        n_start = r_start;
        if (i_update) begin
            if (i_trip) begin
                n_flag  = 1'b1;
                n_start = '0;
            end else if (i_safe) begin
                if (r_flag) begin
                    if (r_start == '0) begin
                        n_start = i_now;
                    end else if (expired) begin
                        n_flag  = 1'b0;
                        n_start = '0;
                    end
                end
            end else begin
                n_start = '0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_flag  <= 1'b0;
            r_start <= '0;
        end else begin
            r_flag  <= n_flag;
            r_start <= n_start;
        end
    end

    assign o_stat.flag = r_flag;
    assign o_stat.busy = (r_start != '0);

endmodule

[tb/sv/tb_battery_fault_latch_with_recovery_core.sv]
// Self-checking testbench for battery_fault_latch_with_recovery_core: random
// sample and result traffic, a built-in latch predictor and per-field checks.
// Depends on bfl_pkg and the RTL under rtl/.
module tb_battery_fault_latch_with_recovery_core
    import bfl_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int CYCLE_LIMIT = 400000;

    typedef struct {
        logic              vld;
        logic [16:0]       volt;
        logic signed [18:0] curr;
        logic signed [11:0] temp;
        logic [31:0]       tms;
    } t_sample;

    typedef struct packed {
        logic ov;
        logic uv;
        logic oc;
        logic ot;
        logic chg;
        logic load;
    } t_flags;

    typedef enum int {MOOD_CALM, MOOD_TRIP, MOOD_EDGE} t_mood;

    // DUT signals; the inputs are known from time zero
    logic                      i_clk = 1'b0;
    logic                      i_rst_n = 1'b0;
    logic                      i_valid = 1'b0;
    logic                      o_ready;
    logic                      i_voltage_valid = 1'b0;
    logic [16:0]               i_battery_voltage_mv = '0;
    logic signed [18:0]        i_battery_current_ma = '0;
    logic signed [11:0]        i_battery_temp_dc = '0;
    logic [31:0]               i_time_ms = '0;
    logic                      o_valid;
    logic                      i_ready = 1'b0;
    logic                      o_over_voltage_fault;
    logic                      o_under_voltage_fault;
    logic                      o_over_current_fault;
    logic                      o_over_temp_fault;
    logic                      o_charge_disable;
    logic                      o_load_disable;
    logic                      i_cfg_we = 1'b0;
    logic [CFG_ADDR_BITS-1:0]  i_cfg_addr = '0;
    logic [CFG_DATA_BITS-1:0]  i_cfg_data = '0;

    // Predictor copy of the limits and latch state
    logic [16:0]        cfg_ov = RST_OV_LIMIT;
    logic [16:0]        cfg_uv = RST_UV_LIMIT;
    logic [17:0]        cfg_oc = RST_OC_LIMIT;
    logic signed [11:0] cfg_ot = RST_OT_LIMIT;
    logic [15:0]        cfg_dly = RST_REC_DELAY;
    bit                 latched [NUM_FLT] = '{default: 1'b0};
    logic [31:0]        timer_start [NUM_FLT] = '{default: 32'd0};
    bit                 chg_off = 1'b0;
    bit                 load_off = 1'b0;

    t_sample     sample_backlog [$];
    t_flags      flags_due [$];
    t_sample     cur_sample;
    logic [31:0] clock_ms = '0;
    t_mood       mood_v, mood_c, mood_t;
    int          burst_left = 0;
    int          tx_gap = 0, tx_steady = 0, rx_hold = 0, rx_steady = 0;
    int          n_queued = 0, n_sent = 0, n_checked = 0, n_fail = 0;
    int          n_sets = 0, n_recov = 0, n_settings = 0;
    int          cycle_cnt = 0;
    t_flags      want, got;

    battery_fault_latch_with_recovery_core u_top (
        .i_clk                 (i_clk),
        .i_rst_n               (i_rst_n),
        .i_valid               (i_valid),
        .o_ready               (o_ready),
        .i_voltage_valid       (i_voltage_valid),
        .i_battery_voltage_mv  (i_battery_voltage_mv),
        .i_battery_current_ma  (i_battery_current_ma),
        .i_battery_temp_dc     (i_battery_temp_dc),
        .i_time_ms             (i_time_ms),
        .o_valid               (o_valid),
        .i_ready               (i_ready),
        .o_over_voltage_fault  (o_over_voltage_fault),
        .o_under_voltage_fault (o_under_voltage_fault),
        .o_over_current_fault  (o_over_current_fault),
        .o_over_temp_fault     (o_over_temp_fault),
        .o_charge_disable      (o_charge_disable),
        .o_load_disable        (o_load_disable),
        .i_cfg_we              (i_cfg_we),
        .i_cfg_addr            (i_cfg_addr),
        .i_cfg_data            (i_cfg_data)
    );

    initial begin
        forever #1 i_clk = ~i_clk;
    end

    // Advance one latch: trip sets it, a safe value runs the recovery timer,
    // anything in the margin band drops the timer back to idle.
    function automatic void step_latch(int k, bit trip, bit safe, logic [31:0] now);
        logic [31:0] elapsed;
        elapsed = now - timer_start[k];
        if (trip) begin
            if (!latched[k]) n_sets++;
            latched[k] = 1'b1;
            timer_start[k] = '0;
        end else if (safe) begin
            if (latched[k]) begin
                if (timer_start[k] == '0) begin
                    timer_start[k] = now;
                end else if (elapsed > 32'(cfg_dly)) begin
                    latched[k] = 1'b0;
                    timer_start[k] = '0;
                    n_recov++;
                end
            end
        end else begin
            timer_start[k] = '0;
        end
    endfunction

    // Update the latches for one sample and return the flags it produces
    function automatic t_flags predict_flags(t_sample s);
        longint v, c, a, t, ov, uv, oc, ot, m_v, m_c, m_t;
        t_flags f;
        if (s.vld) begin
            v = s.volt;
            c = $signed(s.curr);
            a = (c < 0) ? -c : c;
            t = $signed(s.temp);
            ov = cfg_ov;
            uv = cfg_uv;
            oc = cfg_oc;
            ot = cfg_ot;
            m_v = MARGIN_VOLT_MV;
            m_c = MARGIN_CURR_MA;
            m_t = MARGIN_TEMP_DC;
            step_latch(FLT_OV, v > ov, v < ov - m_v, s.tms);
            step_latch(FLT_UV, v < uv, v > uv + m_v, s.tms);
            step_latch(FLT_OC, a > oc, a < oc - m_c, s.tms);
            step_latch(FLT_OT, t > ot, t < ot - m_t, s.tms);
            chg_off = latched[FLT_OV] | latched[FLT_OT];
            load_off = latched[FLT_UV] | latched[FLT_OC] | latched[FLT_OT];
        end
        f.ov = latched[FLT_OV];
        f.uv = latched[FLT_UV];
        f.oc = latched[FLT_OC];
        f.ot = latched[FLT_OT];
        f.chg = chg_off;
        f.load = load_off;
        return f;
    endfunction

    // Idle length: mostly none or short, a few long, with steady runs
    function automatic int pick_gap(ref int steady);
        int r;
        r = $urandom_range(0, 99);
        if (steady > 0) begin
            steady--;
            return 0;
        end
        if (r < 5) begin
            steady = $urandom_range(10, 30);
            return 0;
        end
        if (r < 60) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(6, 30);
    endfunction

    function automatic longint span(longint lo, longint hi);
        if (hi <= lo) return lo;
        return lo + longint'($urandom_range(0, 32'(hi - lo)));
    endfunction

    function automatic longint clampl(longint x, longint lo, longint hi);
        return (x < lo) ? lo : (x > hi) ? hi : x;
    endfunction

    function automatic t_mood pick_mood();
        int r;
        r = $urandom_range(0, 99);
        return (r < 50) ? MOOD_CALM : (r < 75) ? MOOD_TRIP : MOOD_EDGE;
    endfunction

    function automatic longint pick_volt(t_mood mood);
        longint ov, uv, x;
        ov = cfg_ov;
        uv = cfg_uv;
        if ($urandom_range(0, 99) < 6) return span(0, 131071);
        case (mood)
            MOOD_CALM: begin
                if (uv + 1501 < ov - 1501) x = span(uv + 1501, ov - 1501);
                else x = span(0, 131071);
            end
            MOOD_TRIP: begin
                if ($urandom_range(0, 1)) x = ov + 1 + span(0, 300);
                else x = uv - 1 - span(0, 300);
            end
            default: begin
                case ($urandom_range(0, 3))
                    0: x = ov;
                    1: x = ov - 1500;
                    2: x = uv;
                    default: x = uv + 1500;
                endcase
                x = x + span(-2, 2);
            end
        endcase
        return clampl(x, 0, 131071);
    endfunction

    function automatic longint pick_curr(t_mood mood);
        longint oc, m;
        oc = cfg_oc;
        if ($urandom_range(0, 99) < 6) return span(-262144, 262143);
        case (mood)
            MOOD_CALM: m = (oc > 2001) ? span(0, oc - 2001) : span(0, 100);
            MOOD_TRIP: m = oc + 1 + span(0, 500);
            default:   m = ($urandom_range(0, 1) ? oc : oc - 2000) + span(-2, 2);
        endcase
        m = clampl(m, 0, 262144);
        if ($urandom_range(0, 1)) return -m;
        return clampl(m, 0, 262143);
    endfunction

    function automatic longint pick_temp(t_mood mood);
        longint ot, x;
        ot = cfg_ot;
        if ($urandom_range(0, 99) < 6) return span(-2048, 2047);
        case (mood)
            MOOD_CALM: begin
                if (ot - 31 >= -2048) x = span(clampl(ot - 200, -2048, 2047), ot - 31);
                else x = span(-2048, 2047);
            end
            MOOD_TRIP: x = ot + 1 + span(0, 150);
            default:   x = ($urandom_range(0, 1) ? ot : ot - 30) + span(-2, 2);
        endcase
        return clampl(x, -2048, 2047);
    endfunction

    // Move the sample clock: small and recovery-sized steps, jumps, zero, wrap
    function automatic void advance_clock();
        int r;
        int unsigned d;
        d = cfg_dly;
        r = $urandom_range(0, 99);
        if (r < 45) clock_ms += $urandom_range(0, d / 4 + 1);
        else if (r < 85) clock_ms += $urandom_range(d / 2, d + 2);
        else if (r < 89) clock_ms = $urandom;
        else if (r < 91) clock_ms = '0;
        else if (r < 93) clock_ms = 32'hFFFF_FFFF - $urandom_range(0, d + 3);
        // otherwise hold the clock
    endfunction

    function automatic void add_sample(bit vld, longint v, longint c, longint t,
                                       logic [31:0] ms);
        t_sample s;
        s.vld = vld;
        s.volt = 17'(v);
        s.curr = 19'(c);
        s.temp = 12'(t);
        s.tms = ms;
        sample_backlog.push_back(s);
        n_queued++;
    endfunction

    // Bursts share one mood per channel so trip-then-recover runs occur
    function automatic void queue_random(int n);
        for (int i = 0; i < n; i++) begin
            if (burst_left == 0) begin
                mood_v = pick_mood();
                mood_c = pick_mood();
                mood_t = pick_mood();
                burst_left = $urandom_range(3, 20);
            end
            burst_left--;
            advance_clock();
            if ($urandom_range(0, 99) < 8)
                add_sample(1'b0, span(0, 131071), span(-262144, 262143),
                           span(-2048, 2047), $urandom);
            else
                add_sample(1'b1, pick_volt(mood_v), pick_curr(mood_c),
                           pick_temp(mood_t), clock_ms);
        end
    endfunction

    task automatic drain();
        while (n_checked < n_queued) @(posedge i_clk);
        repeat (3) @(posedge i_clk);
    endtask

    task automatic write_reg(t_reg_idx idx, logic [CFG_DATA_BITS-1:0] data);
        @(posedge i_clk);
        i_cfg_we <= 1'b1;
        i_cfg_addr <= idx;
        i_cfg_data <= data;
    endtask

    task automatic load_config(logic [16:0] ov, logic [16:0] uv, logic [17:0] oc,
                               logic signed [11:0] ot, logic [15:0] dly);
        write_reg(REG_OV_LIMIT, CFG_DATA_BITS'(ov));
        write_reg(REG_UV_LIMIT, CFG_DATA_BITS'(uv));
        write_reg(REG_OC_LIMIT, CFG_DATA_BITS'(oc));
        write_reg(REG_OT_LIMIT, CFG_DATA_BITS'(ot));
        write_reg(REG_REC_DELAY, CFG_DATA_BITS'(dly));
        @(posedge i_clk);
        i_cfg_we <= 1'b0;
        cfg_ov = ov;
        cfg_uv = uv;
        cfg_oc = oc;
        cfg_ot = ot;
        cfg_dly = dly;
        n_settings++;
    endtask

    // Write a setting while idle, then random traffic with a full drain midway
    task automatic run_phase(logic [16:0] ov, logic [16:0] uv, logic [17:0] oc,
                             logic signed [11:0] ot, logic [15:0] dly, int n);
        drain();
        load_config(ov, uv, oc, ot, dly);
        queue_random(n / 2);
        drain();
        queue_random(n - n / 2);
    endtask

    function automatic void check_bit(string name, logic exp_b, logic act_b);
        if (exp_b !== act_b) begin
            $display("%0t ns: %s mismatch, expected %0b, actual %0b",
                     $time, name, exp_b, act_b);
            n_fail++;
        end
    endfunction

    // Sample driver: hold the beat until accepted, then predict it
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
            tx_gap = 0;
        end else begin
            if (i_valid && o_ready) begin
                flags_due.push_back(predict_flags(cur_sample));
                n_sent++;
            end
            if (!i_valid || o_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    i_valid <= 1'b0;
                end else if (sample_backlog.size() > 0) begin
                    cur_sample = sample_backlog.pop_front();
                    i_voltage_valid <= cur_sample.vld;
                    i_battery_voltage_mv <= cur_sample.volt;
                    i_battery_current_ma <= cur_sample.curr;
                    i_battery_temp_dc <= cur_sample.temp;
                    i_time_ms <= cur_sample.tms;
                    i_valid <= 1'b1;
                    tx_gap = pick_gap(tx_steady);
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: compare each beat with the oldest prediction, stall at random
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
            rx_hold = 0;
        end else begin
            if (o_valid && i_ready) begin
                if (flags_due.size() == 0) begin
                    $display("%0t ns: result beat with nothing expected", $time);
                    n_fail++;
                end else begin
                    want = flags_due.pop_front();
                    got = {o_over_voltage_fault, o_under_voltage_fault,
                           o_over_current_fault, o_over_temp_fault,
                           o_charge_disable, o_load_disable};
                    check_bit("over_voltage_fault", want.ov, got.ov);
                    check_bit("under_voltage_fault", want.uv, got.uv);
                    check_bit("over_current_fault", want.oc, got.oc);
                    check_bit("over_temp_fault", want.ot, got.ot);
                    check_bit("charge_disable", want.chg, got.chg);
                    check_bit("load_disable", want.load, got.load);
                    n_checked++;
                end
            end
            if (rx_hold > 0) begin
                rx_hold--;
                i_ready <= 1'b0;
            end else begin
                i_ready <= 1'b1;
                rx_hold = pick_gap(rx_steady);
            end
        end
    end

    // Watchdog
    always @(posedge i_clk) begin
        cycle_cnt++;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("%0t ns: timeout, %0d of %0d results seen", $time, n_checked, n_queued);
            $display("TB_ERROR");
            $finish;
        end
    end

    initial begin
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed samples against the default limits
        load_config(RST_OV_LIMIT, RST_UV_LIMIT, RST_OC_LIMIT, RST_OT_LIMIT, RST_REC_DELAY);
        add_sample(1'b1, 48000, 0, 250, 32'd100);
        add_sample(1'b1, 54601, 30001, 601, 32'd200);         // just over three limits
        add_sample(1'b0, 0, -262144, -2048, 32'd250);         // invalid, state must hold
        add_sample(1'b1, 54600, 30000, 600, 32'd300);         // exactly on the limits
        add_sample(1'b1, 53099, 27999, 569, 32'd400);         // safe side, timers start
        add_sample(1'b1, 53099, -27999, 569, 32'd3400);       // elapsed equals delay, hold
        add_sample(1'b1, 53099, 27999, 569, 32'd3401);        // one past delay, clear
        add_sample(1'b1, 41999, 0, 250, 32'd3500);            // under-voltage trip
        add_sample(1'b1, 0, 0, -2048, 32'd3600);
        add_sample(1'b1, 43501, 0, 250, 32'd0);               // safe at time zero stays idle
        add_sample(1'b1, 43501, 0, 250, 32'd5);
        add_sample(1'b1, 43500, 0, 250, 32'd10);              // margin band restarts timer
        add_sample(1'b1, 131071, 262143, 2047, 32'hFFFF_FF00);
        add_sample(1'b1, 48000, -262144, -400, 32'h0000_0C00); // time has wrapped, timers start
        add_sample(1'b1, 48000, 0, -400, 32'h0000_1800);
        add_sample(1'b0, 131071, 262143, 2047, 32'hFFFF_FFFF);
        add_sample(1'b1, 48000, 0, 0, 32'hFFFF_FFFF);
        clock_ms = 32'hFFFF_FFFF;
        queue_random(80);

        // Extremes, limits near zero, tight delays and a random setting
        run_phase(17'd0, 17'd131071, 18'd0, 12'sh800, 16'd0, 80);
        run_phase(17'd131071, 17'd0, 18'd262143, 12'sd2047, 16'd65535, 80);
        run_phase(17'd50000, 17'd45000, 18'd1000, -12'sd400, 16'd5, 80);
        run_phase(17'($urandom_range(20000, 131071)), 17'($urandom_range(0, 60000)),
                  18'($urandom_range(0, 262143)), 12'(int'($urandom_range(0, 1900)) - 400),
                  16'($urandom_range(0, 200)), 80);
        run_phase(RST_OV_LIMIT, RST_UV_LIMIT, RST_OC_LIMIT, 12'sd1500, 16'd1, 80);

        drain();
        repeat (5) @(posedge i_clk);
        if (flags_due.size() != 0) begin
            $display("%0d predicted results never arrived", flags_due.size());
            n_fail++;
        end
        $display("Covered %0d samples under %0d limit settings, %0d results compared.",
                 n_sent, n_settings, n_checked);
        $display("Predicted %0d fault sets and %0d timed recoveries; %0d mismatches.",
                 n_sets, n_recov, n_fail);
        if (n_fail == 0) $display("TB_OK");
        else $display("TB_ERROR");
        $finish;
    end

endmodule

[sim.f]
rtl/bfl_pkg.sv
rtl/bfl_cfg_regs.sv
rtl/bfl_latch.sv
rtl/battery_fault_latch_with_recovery_core.sv
tb/sv/tb_battery_fault_latch_with_recovery_core.sv
